// ----- src/fvc_pkg.sv -----
`default_nettype none

package fvc_pkg;

  // Field widths of the item and result words.
  localparam int unsigned LEVEL_W  = 12;
  localparam int unsigned IR_W     = 8;
  localparam int unsigned SER_W    = 2;
  localparam int unsigned KEY_W    = 2;
  localparam int unsigned DELAY_W  = 6;
  localparam int unsigned SAFETY_W = 12;

  // Sensor resolution: only the low LEVEL_BITS bits of a sample are used (at most LEVEL_W, 12).
  localparam int unsigned LEVEL_BITS = 12;
  localparam logic [LEVEL_W-1:0] LEVEL_MASK = LEVEL_W'((33'd1 << LEVEL_BITS) - 33'd1);

  // Stream and configuration port widths.
  localparam int unsigned IN_DATA_W  = 24;
  localparam int unsigned OUT_DATA_W = 8;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 12;

  typedef enum logic {
    OP_TICK = 1'b0,
    OP_CMD  = 1'b1
  } op_e;

  typedef enum logic [1:0] {
    STAT_FULL    = 2'd0,
    STAT_FILLING = 2'd1,
    STAT_IDLE    = 2'd2
  } status_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_FULL_TH    = 3'd0,
    REG_ALARM_TH   = 3'd1,
    REG_DELAY      = 3'd2,
    REG_SAFETY     = 3'd3,
    REG_KEY_PERIOD = 3'd4,
    REG_OPEN_CODE  = 3'd5,
    REG_CLOSE_CODE = 3'd6
  } reg_idx_e;

  localparam logic [SER_W-1:0] SER_OPEN  = 2'd1;
  localparam logic [SER_W-1:0] SER_CLOSE = 2'd2;
  localparam logic [IR_W-1:0]  IR_NONE   = 8'd0;

  typedef struct packed {
    logic [LEVEL_W-1:0]  full_th;
    logic [LEVEL_W-1:0]  alarm_th;
    logic [DELAY_W-1:0]  delay;
    logic [SAFETY_W-1:0] safety;
    logic [KEY_W-1:0]    key_period;
    logic [IR_W-1:0]     open_code;
    logic [IR_W-1:0]     close_code;
  } cfg_t;

  typedef struct packed {
    op_e                op;
    logic [SER_W-1:0]   serial_cmd;
    logic [IR_W-1:0]    ir_code;
    logic               key_pressed;
    logic [LEVEL_W-1:0] level;
  } item_t;

  typedef struct packed {
    logic [LEVEL_W-1:0]  level;
    logic                full;
    logic                valve;
    logic [KEY_W-1:0]    key_cnt;
    logic [DELAY_W-1:0]  delay_cnt;
    logic [SAFETY_W-1:0] safety_cnt;
  } state_t;

  // Packed so that valve_on lands in bit 0 of the result word.
  typedef struct packed {
    status_e status;
    logic    alarm;
    logic    tank_full;
    logic    valve_on;
  } result_t;

endpackage

`default_nettype wire

// ----- src/fvc_step.sv -----
`default_nettype none

module fvc_step (
  input  fvc_pkg::cfg_t    cfg_i,
  input  fvc_pkg::state_t  state_i,
  input  fvc_pkg::item_t   item_i,
  output fvc_pkg::state_t  state_o,
  output fvc_pkg::result_t result_o
);
  import fvc_pkg::*;

  logic [LEVEL_W-1:0]  lvl;
  logic                full;
  logic [KEY_W-1:0]    key_inc;
  logic [DELAY_W-1:0]  delay_inc;
  logic [SAFETY_W-1:0] safety_inc;
  logic                open_req;
  logic                close_req;
  state_t              nxt;

  assign lvl  = item_i.level & LEVEL_MASK;
  assign full = lvl > cfg_i.full_th;

  assign open_req  = ((item_i.ir_code != IR_NONE) && (item_i.ir_code == cfg_i.open_code)) ||
                     (item_i.serial_cmd == SER_OPEN);
  assign close_req = ((item_i.ir_code != IR_NONE) && (item_i.ir_code == cfg_i.close_code)) ||
                     (item_i.serial_cmd == SER_CLOSE);

  always_comb begin
    nxt        = state_i;
    key_inc    = KEY_W'(state_i.key_cnt + 1'b1);
    delay_inc  = DELAY_W'(state_i.delay_cnt + 1'b1);
    safety_inc = '0;
    unique case (item_i.op)
      OP_TICK: begin
        nxt.level   = lvl;
        nxt.full    = full;
        nxt.key_cnt = key_inc;
        if (key_inc == cfg_i.key_period) begin
          nxt.key_cnt = '0;
          if (item_i.key_pressed && !full) begin
            nxt.valve = 1'b1;
          end
        end
        // The delay counter holds its value while the tank is not full.
        if (full) begin
          nxt.delay_cnt = delay_inc;
          if (delay_inc == cfg_i.delay) begin
            nxt.delay_cnt = '0;
            nxt.valve     = 1'b0;
          end
        end
        safety_inc = SAFETY_W'(state_i.safety_cnt + 1'b1);
        if (nxt.valve) begin
          nxt.safety_cnt = safety_inc;
          if (safety_inc == cfg_i.safety) begin
            nxt.safety_cnt = '0;
            nxt.valve      = 1'b0;
          end
        end
      end
      OP_CMD: begin
        if (open_req && !state_i.full) begin
          nxt.valve = 1'b1;
        end else if (close_req) begin
          nxt.valve      = 1'b0;
          nxt.safety_cnt = '0;
        end
      end
      default: begin
        nxt = state_i;
      end
    endcase
  end

  assign state_o = nxt;

  always_comb begin
    result_o.valve_on  = nxt.valve;
    result_o.tank_full = nxt.full;
    result_o.alarm     = nxt.full && (nxt.level > cfg_i.alarm_th);
    if (nxt.full) begin
      result_o.status = STAT_FULL;
    end else if (nxt.valve) begin
      result_o.status = STAT_FILLING;
    end else begin
      result_o.status = STAT_IDLE;
    end
  end

endmodule

`default_nettype wire

// ----- src/fill_valve_controller.sv -----
// Fill valve controller.
// Input stream: one word per event. tuser selects the kind: a timer tick that
// carries a level sample and the fill key state, or a remote command that
// carries an infrared code and a serial command. Every word yields exactly one
// result word with the valve drive, the full flag, the alarm and a status code.
// Configuration registers (thresholds, delays, codes) are written through the
// cfg channel, which is always ready; write them only while no word is in flight.
// The word is captured in an input register, and the next state and the result
// are computed in one pass of compare-and-count logic into the result register.
// The result is registered: an accepted word passes the input register and then
// the result register. One word is accepted every cycle as long as the result
// side keeps up.
// When the receiver stalls, the result register holds its word, the input
// register holds one more, and s_axis_tready drops until the result is taken.
// Reset clears the valve (closed), the full flag, the stored level and all
// counters, and loads the default register values.
`default_nettype none

module fill_valve_controller (
  input  wire                              clk_i,
  input  wire                              rst_ni,
  // Configuration write channel.
  input  wire                              cfg_valid_i,
  output logic                             cfg_ready_o,
  input  wire [fvc_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  wire [fvc_pkg::CFG_DATA_W-1:0]    cfg_data_i,
  // Input stream.
  input  wire                              s_axis_tvalid,
  output logic                             s_axis_tready,
  // tdata: level[11:0], key_pressed[12], ir_code[20:13], serial_cmd[22:21], zero[23]
  input  wire [fvc_pkg::IN_DATA_W-1:0]     s_axis_tdata,
  // tuser: op[0]
  input  wire                              s_axis_tuser,
  // Result stream.
  output logic                             m_axis_tvalid,
  input  wire                              m_axis_tready,
  // tdata: valve_on[0], tank_full[1], alarm[2], status[4:3], zero[7:5]
  output logic [fvc_pkg::OUT_DATA_W-1:0]   m_axis_tdata
);
  import fvc_pkg::*;

  cfg_t    cfg_q;
  state_t  state_q;
  state_t  state_d;
  item_t   item_q;
  item_t   item_in;
  logic    in_valid_q;
  result_t result_q;
  result_t result_d;
  logic    out_valid_q;
  logic    advance;
  logic    in_take;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.full_th    <= 12'd2100;
      cfg_q.alarm_th   <= 12'd2500;
      cfg_q.delay      <= 6'd40;
      cfg_q.safety     <= 12'd2500;
      cfg_q.key_period <= 2'd2;
      cfg_q.open_code  <= 8'd71;
      cfg_q.close_code <= 8'd69;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        REG_FULL_TH:    cfg_q.full_th    <= cfg_data_i[LEVEL_W-1:0];
        REG_ALARM_TH:   cfg_q.alarm_th   <= cfg_data_i[LEVEL_W-1:0];
        REG_DELAY:      cfg_q.delay      <= cfg_data_i[DELAY_W-1:0];
        REG_SAFETY:     cfg_q.safety     <= cfg_data_i[SAFETY_W-1:0];
        REG_KEY_PERIOD: cfg_q.key_period <= cfg_data_i[KEY_W-1:0];
        REG_OPEN_CODE:  cfg_q.open_code  <= cfg_data_i[IR_W-1:0];
        REG_CLOSE_CODE: cfg_q.close_code <= cfg_data_i[IR_W-1:0];
        default: begin
          cfg_q <= cfg_q;
        end
      endcase
    end
  end

  // The input register moves on whenever the result register is free or being drained.
  assign advance       = in_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || advance;
  assign in_take       = s_axis_tvalid && s_axis_tready;

  always_comb begin
    item_in.op          = op_e'(s_axis_tuser);
    item_in.level       = s_axis_tdata[11:0];
    item_in.key_pressed = s_axis_tdata[12];
    item_in.ir_code     = s_axis_tdata[20:13];
    item_in.serial_cmd  = s_axis_tdata[22:21];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      item_q <= item_in;
    end
  end

  fvc_step u_step (
    .cfg_i    (cfg_q),
    .state_i  (state_q),
    .item_i   (item_q),
    .state_o  (state_d),
    .result_o (result_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= '0;
    end else if (advance) begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      result_q <= result_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {3'b000, result_q};

  // A full result always reports the full status, and only a full result does.
  a_status_full : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (result_q.tank_full == (result_q.status == STAT_FULL)))
    else $error("status and full flag disagree");

  // The alarm is only raised on a full tank.
  a_alarm_full : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && result_q.alarm |-> result_q.tank_full)
    else $error("alarm without full flag");

  // A waiting word in the input register stays put while the result side is blocked.
  a_in_hold : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_q && !advance |=> in_valid_q && $stable(item_q) && $stable(state_q))
    else $error("input word or state changed while blocked");

  // The state only moves together with a new result word.
  a_state_step : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !advance |=> $stable(state_q))
    else $error("state changed without a word");

endmodule

`default_nettype wire
